[rtl/core/ism_pkg.sv]
// ----------------------------------------------------------------------------
// ism_pkg
// Shared types and constants for the interval set merge and lookup core.
// ----------------------------------------------------------------------------
`default_nettype none

package ism_pkg;

    // field widths of the stream items
    localparam int ID_W    = 50;
    localparam int ENT_W   = 11;
    localparam int COV_W   = 51;
    localparam int HCNT_W  = 32;
    localparam int IN_W    = 104;
    localparam int OUT_W   = 104;

    // item kinds
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_REVERSED = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_LK_CHK,
        S_LK_CMP,
        S_F_CHK,
        S_F_CMP,
        S_M_CHK,
        S_M_CMP,
        S_DECIDE,
        S_SH_CHK,
        S_SH_WR,
        S_DONE
    } state_t;

    // datapath command, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_LK_RD,
        OP_LK_GT,
        OP_LK_LT,
        OP_LK_HIT,
        OP_F_RD,
        OP_F_ADV,
        OP_M_INIT,
        OP_M_RD,
        OP_M_TAKE,
        OP_SH_INIT,
        OP_SH_RD,
        OP_SH_WR,
        OP_WR_NEW,
        OP_FULL,
        OP_REV,
        OP_PUSH
    } op_t;

    // datapath flags seen by the controller
    typedef struct packed {
        logic is_lookup;
        logic reversed;
        logic lk_active;
        logic lk_gt;
        logic lk_lt;
        logic f_more;
        logic f_adv;
        logic m_more;
        logic m_take;
        logic k_zero;
        logic full;
        logic sh_more;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

[rtl/core/ism_dp.sv]
// ----------------------------------------------------------------------------
// ism_dp
// Range table memories, search pointers, merge registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ism_dp #(
    parameter int TABLE_DEPTH = 1024,
    parameter int ID_BITS     = 50
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tuser,   // cmd
    input  wire logic [ism_pkg::IN_W-1:0]  s_tdata,   // low_id, high_id
    input  wire ism_pkg::op_t              op,
    output ism_pkg::stat_t                 st,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [ism_pkg::OUT_W-1:0]      m_tdata    // hit, status, entries_used,
                                                       // covered_total, hits_so_far
);
    import ism_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int MB = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}} >> (ID_W - MB);

    logic [ID_W-1:0]   mem_s [TABLE_DEPTH];
    logic [ID_W-1:0]   mem_e [TABLE_DEPTH];
    logic [ID_W-1:0]   rd_s_reg, rd_e_reg;

    logic [ID_W-1:0]   lo_reg, hi_reg, ns_reg, ne_reg;
    logic              cmd_reg, hit_reg;
    logic [1:0]        stat_reg;
    logic [CW-1:0]     a_reg, b_reg, idx_reg, mid_reg, cnt_reg;
    logic [COV_W-1:0]  rem_reg, cov_reg;
    logic [HCNT_W-1:0] hcnt_reg;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    logic [CW-1:0]     mid, k, rd_idx, wr_idx;
    logic [AW-1:0]     raddr, waddr;
    logic              we;
    logic [ID_W-1:0]   wd_s, wd_e;
    logic [COV_W-1:0]  rd_len, new_len;

    // pointer arithmetic
    assign mid    = a_reg + ((b_reg - a_reg) >> 1);
    assign k      = b_reg - a_reg;
    assign rd_idx = st.k_zero ? (idx_reg - CW'(1)) : idx_reg;
    assign wr_idx = st.k_zero ? idx_reg : (a_reg + CW'(1) + (idx_reg - b_reg));
    assign rd_len = {1'b0, rd_e_reg} - {1'b0, rd_s_reg} + COV_W'(1);
    assign new_len = {1'b0, ne_reg} - {1'b0, ns_reg} + COV_W'(1);

    // flags for the controller
    always_comb
    begin
        st.is_lookup = (cmd_reg == CMD_LOOKUP);
        st.reversed  = (lo_reg > hi_reg);
        st.lk_active = (a_reg < b_reg);
        st.lk_gt     = (rd_s_reg > lo_reg);
        st.lk_lt     = (rd_e_reg < lo_reg);
        st.f_more    = (a_reg < cnt_reg);
        st.f_adv     = (({1'b0, rd_e_reg} + 51'(1)) < {1'b0, lo_reg});
        st.m_more    = (b_reg < cnt_reg);
        st.m_take    = ({1'b0, rd_s_reg} <= ({1'b0, hi_reg} + 51'(1)));
        st.k_zero    = (b_reg == a_reg);
        st.full      = (cnt_reg >= CW'(TABLE_DEPTH));
        st.sh_more   = st.k_zero ? (idx_reg > a_reg)
                                 : ((k > CW'(1)) && (idx_reg < cnt_reg));
        st.out_free  = !m_tvalid_reg || m_tready;
    end

    // memory port selection
    always_comb
    begin
        raddr = a_reg[AW-1:0];
        we    = 1'b0;
        waddr = a_reg[AW-1:0];
        wd_s  = rd_s_reg;
        wd_e  = rd_e_reg;
        unique case (op)
            OP_LK_RD: raddr = mid[AW-1:0];
            OP_M_RD:  raddr = b_reg[AW-1:0];
            OP_SH_RD: raddr = rd_idx[AW-1:0];
            OP_SH_WR:
            begin
                we    = 1'b1;
                waddr = wr_idx[AW-1:0];
            end
            OP_WR_NEW:
            begin
                we   = 1'b1;
                wd_s = ns_reg;
                wd_e = ne_reg;
            end
            default: ;
        endcase
    end

    // range table
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_s[waddr] <= wd_s;
            mem_e[waddr] <= wd_e;
        end
        rd_s_reg <= mem_s[raddr];
        rd_e_reg <= mem_e[raddr];
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                cmd_reg <= s_tuser;
                lo_reg  <= s_tdata[ID_W-1:0] & ID_MASK;
                hi_reg  <= s_tdata[2*ID_W-1:ID_W] & ID_MASK;
                a_reg   <= '0;
                b_reg   <= cnt_reg;
            end
            OP_LK_RD:  mid_reg <= mid;
            OP_LK_GT:  b_reg <= mid_reg;
            OP_LK_LT:  a_reg <= mid_reg + CW'(1);
            OP_F_ADV:  a_reg <= a_reg + CW'(1);
            OP_M_INIT:
            begin
                b_reg   <= a_reg;
                ns_reg  <= lo_reg;
                ne_reg  <= hi_reg;
                rem_reg <= '0;
            end
            OP_M_TAKE:
            begin
                if (rd_s_reg < ns_reg)
                begin
                    ns_reg <= rd_s_reg;
                end
                if (rd_e_reg > ne_reg)
                begin
                    ne_reg <= rd_e_reg;
                end
                rem_reg <= rem_reg + rd_len;
                b_reg   <= b_reg + CW'(1);
            end
            OP_SH_INIT: idx_reg <= st.k_zero ? cnt_reg : b_reg;
            OP_SH_WR:   idx_reg <= st.k_zero ? (idx_reg - CW'(1)) : (idx_reg + CW'(1));
            default: ;
        endcase
    end

    // architectural state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            cov_reg      <= '0;
            hcnt_reg     <= '0;
            hit_reg      <= 1'b0;
            stat_reg     <= ST_OK;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            // result valid set by a push, cleared once taken
            if (op == OP_PUSH)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (op)
                OP_LOAD:
                begin
                    hit_reg  <= 1'b0;
                    stat_reg <= ST_OK;
                end
                OP_LK_HIT:
                begin
                    hit_reg <= 1'b1;
                    if (hcnt_reg != {HCNT_W{1'b1}})
                    begin
                        hcnt_reg <= hcnt_reg + HCNT_W'(1);
                    end
                end
                OP_FULL: stat_reg <= ST_FULL;
                OP_REV:  stat_reg <= ST_REVERSED;
                OP_WR_NEW:
                begin
                    cnt_reg <= cnt_reg - k + CW'(1);
                    cov_reg <= cov_reg - rem_reg + new_len;
                end
                OP_PUSH:
                begin
                    m_tdata_reg  <= {7'b0, hcnt_reg, cov_reg, ENT_W'(cnt_reg),
                                     stat_reg, hit_reg};
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

[rtl/core/ism_ctrl.sv]
// ----------------------------------------------------------------------------
// ism_ctrl
// Sequencer for binary search, merge scan, table shift and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ism_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire ism_pkg::stat_t st,
    output ism_pkg::op_t        op
);
    import ism_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_START;
            S_START:
            begin
                if (st.is_lookup)     state_next = S_LK_CHK;
                else if (st.reversed) state_next = S_DONE;
                else                  state_next = S_F_CHK;
            end
            S_LK_CHK: state_next = st.lk_active ? S_LK_CMP : S_DONE;
            S_LK_CMP: state_next = (st.lk_gt || st.lk_lt) ? S_LK_CHK : S_DONE;
            S_F_CHK:  state_next = st.f_more ? S_F_CMP : S_M_CHK;
            S_F_CMP:  state_next = st.f_adv ? S_F_CHK : S_M_CHK;
            S_M_CHK:  state_next = st.m_more ? S_M_CMP : S_DECIDE;
            S_M_CMP:  state_next = st.m_take ? S_M_CHK : S_DECIDE;
            S_DECIDE: state_next = (st.k_zero && st.full) ? S_DONE : S_SH_CHK;
            S_SH_CHK: state_next = st.sh_more ? S_SH_WR : S_DONE;
            S_SH_WR:  state_next = S_SH_CHK;
            S_DONE:   if (st.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        op       = OP_NONE;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid) op = OP_LOAD;
            end
            S_START:  if (!st.is_lookup && st.reversed) op = OP_REV;
            S_LK_CHK: if (st.lk_active) op = OP_LK_RD;
            S_LK_CMP:
            begin
                priority if (st.lk_gt) op = OP_LK_GT;
                else if (st.lk_lt)     op = OP_LK_LT;
                else                   op = OP_LK_HIT;
            end
            S_F_CHK:  op = st.f_more ? OP_F_RD : OP_M_INIT;
            S_F_CMP:  op = st.f_adv ? OP_F_ADV : OP_M_INIT;
            S_M_CHK:  if (st.m_more) op = OP_M_RD;
            S_M_CMP:  if (st.m_take) op = OP_M_TAKE;
            S_DECIDE: op = (st.k_zero && st.full) ? OP_FULL : OP_SH_INIT;
            S_SH_CHK: op = st.sh_more ? OP_SH_RD : OP_WR_NEW;
            S_SH_WR:  op = OP_SH_WR;
            S_DONE:   if (st.out_free) op = OP_PUSH;
            default:  op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/interval_set_merge_lookup_core.sv]
// ----------------------------------------------------------------------------
// interval_set_merge_lookup_core
// Sorted table of disjoint closed ID ranges with merging insert and lookup.
// ----------------------------------------------------------------------------
// Input channel s_*: tuser is the command (0 insert, 1 lookup), tdata holds
// low_id and high_id. Output channel m_*: one result item per input item with
// hit, status, entry count, covered ID total and saturating hit count.
// One item is in work at a time; the next is taken once the result of the
// previous one sits in the output register, so a stalled receiver holds only
// that register and the next item may already be under way.
// Lookup: a binary search, each step a table read followed by a compare.
// Insert: each entry scanned up to the merge point, each merged entry and
// each entry shifted costs a read step and a compare or write step, set by
// the single read port of the range table, with one read or one write per entry step.
// Reset empties the table (entry count, covered total and hit count go to
// zero); no clearing pass over the table memory is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_set_merge_lookup_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int ID_BITS     = 50
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic                      s_tuser,   // cmd
    input  wire logic [ism_pkg::IN_W-1:0]  s_tdata,   // low_id, high_id
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [ism_pkg::OUT_W-1:0]      m_tdata    // hit, status, entries_used,
                                                       // covered_total, hits_so_far
);
    import ism_pkg::*;

    op_t   op;
    stat_t st;

    // sequencer
    ism_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .op       (op)
    );

    // table and arithmetic
    ism_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .op       (op),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item taken while previous item still in work");

    // a result appears only from the push command
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(op == OP_PUSH))
        else $error("result raised without push");

    // an insert is only refused as full when it merges nothing and the table is full
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_FULL) |-> (st.full && st.k_zero))
        else $error("insert refused with room left");
`endif

endmodule

`default_nettype wire
